FILE: rtl/rccs_pkg.sv
// ----------------------------------------------------------------------------
// rccs_pkg
// Shared widths, codes and reset values of the colour scorer: sample and
// centroid widths, phase and LED codes, register indexes and the command
// word that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package rccs_pkg;

  // field widths
  localparam int SAMPLE_W = 10;
  localparam int CENT_W   = 48;
  localparam int COMP_W   = 16;
  localparam int DIST_W   = 32;
  localparam int LED_W    = 2;
  localparam int CFG_IDX_W = 2;

  // default measurement length per phase
  localparam int SPP_DEFAULT = 4;

  // phase of a sample, equal to the LED lit while it is taken
  typedef logic [LED_W-1:0] phase_t;
  localparam phase_t PH_AMBIENT = 2'd0;
  localparam phase_t PH_RED     = 2'd1;
  localparam phase_t PH_GREEN   = 2'd2;
  localparam phase_t PH_BLUE    = 2'd3;

  // centroid selector, also the register index of each centroid
  typedef logic [CFG_IDX_W-1:0] cent_sel_t;
  localparam cent_sel_t CENT_EDGE   = 2'd0;
  localparam cent_sel_t CENT_METAL  = 2'd1;
  localparam cent_sel_t CENT_YELLOW = 2'd2;

  // centroid reset values, quarter units, red in the top field
  localparam logic [CENT_W-1:0] EDGE_RESET   = 48'h0194_03CF_0463;
  localparam logic [CENT_W-1:0] METAL_RESET  = 48'h1251_1B33_1E63;
  localparam logic [CENT_W-1:0] YELLOW_RESET = 48'h238A_09B7_1E34;

  // controller to datapath command word
  typedef struct packed {
    logic      accum;   // add the sample into the sum of phase
    phase_t    phase;
    logic      diff;    // form colour minus ambient, clear the sums
    logic      square;  // square the three differences for sel
    logic      add;     // sum the squares, saturate, store for sel
    cent_sel_t sel;
  } dp_cmd_t;

endpackage

FILE: rtl/rgb_centroid_color_scorer.sv
// ----------------------------------------------------------------------------
// rgb_centroid_color_scorer
// Light-sensor colour scorer: sums ambient, red, green and blue samples of a
// measurement and scores the ambient-corrected colour against three centroids
// by squared distance.
//
//   channel  | ports                                        | handshake
//   ---------+----------------------------------------------+-----------------
//   sample   | sample                                       | start & !busy
//   result   | led_select done_res dist_edge/metal/yellow   | result_valid
//   config   | cfg_index cfg_data                           | cfg_write
//
// A sample that does not end a measurement has its word strobed the next
// cycle, and busy stays low.
// After the last sample of a measurement busy goes high while the ambient
// sum is subtracted, then a square step and an add step run per centroid
// on the three shared squarers; the word is strobed after the third add.
// Reset (rst, synchronous) clears the counters and sums and reloads the
// centroid registers with their defaults.
// The receiver cannot stall: each word is present for one cycle only.
// ----------------------------------------------------------------------------
module rgb_centroid_color_scorer #(
  parameter int SAMPLES_PER_PHASE = rccs_pkg::SPP_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [rccs_pkg::SAMPLE_W-1:0]  sample,
  output logic                           result_valid,
  output logic [rccs_pkg::LED_W-1:0]     led_select,
  output logic                           done_res,
  output logic [rccs_pkg::DIST_W-1:0]    dist_edge,
  output logic [rccs_pkg::DIST_W-1:0]    dist_metal,
  output logic [rccs_pkg::DIST_W-1:0]    dist_yellow,
  input  logic                           cfg_write,
  input  logic [rccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rccs_pkg::CENT_W-1:0]    cfg_data
);
  import rccs_pkg::*;

  dp_cmd_t cmd;

  // sequencing
  rccs_ctrl #(
    .SAMPLES_PER_PHASE(SAMPLES_PER_PHASE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .led_select   (led_select),
    .done_res     (done_res),
    .cmd          (cmd)
  );

  // sums, centroids and distances
  rccs_datapath #(
    .SAMPLES_PER_PHASE(SAMPLES_PER_PHASE)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sample      (sample),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .dist_edge   (dist_edge),
    .dist_metal  (dist_metal),
    .dist_yellow (dist_yellow)
  );

endmodule

FILE: rtl/rccs_ctrl.sv
// ----------------------------------------------------------------------------
// rccs_ctrl
// Controller of the colour scorer: counts samples through the four phases,
// sequences the distance work after the last sample and drives the result
// strobe, the LED choice and the completion flag.
// ----------------------------------------------------------------------------
module rccs_ctrl #(
  parameter int SAMPLES_PER_PHASE = rccs_pkg::SPP_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  output logic                    result_valid,
  output logic [rccs_pkg::LED_W-1:0] led_select,
  output logic                    done_res,
  output rccs_pkg::dp_cmd_t       cmd
);
  import rccs_pkg::*;

  localparam int SUB_W = (SAMPLES_PER_PHASE > 1) ? $clog2(SAMPLES_PER_PHASE) : 1;
  localparam logic [SUB_W-1:0] LAST_SUB = SUB_W'(SAMPLES_PER_PHASE - 1);

  // state codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_DIFF   = 2'd1;
  localparam logic [1:0] ST_SQUARE = 2'd2;
  localparam logic [1:0] ST_ADD    = 2'd3;

  logic [1:0]       state, state_next;
  phase_t           phase, phase_next;
  logic [SUB_W-1:0] sub, sub_next;
  cent_sel_t        sel, sel_next;
  logic             result_valid_next;
  phase_t           led_next;
  logic             done_next;
  logic             accept;
  logic             last_sample;

  assign accept      = start && (state == ST_IDLE);
  assign last_sample = (phase == PH_BLUE) && (sub == LAST_SUB);
  assign busy        = (state != ST_IDLE);

  // next state and counters
  always_comb begin
    state_next        = state;
    phase_next        = phase;
    sub_next          = sub;
    sel_next          = sel;
    result_valid_next = 1'b0;
    led_next          = led_select;
    done_next         = 1'b0;
    cmd               = '0;
    cmd.phase         = phase;
    cmd.sel           = sel;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.accum = 1'b1;
          if (last_sample) begin
            state_next = ST_DIFF;
            phase_next = PH_AMBIENT;
            sub_next   = '0;
          end else begin
            result_valid_next = 1'b1;
            if (sub == LAST_SUB) begin
              sub_next   = '0;
              phase_next = phase + 2'd1;
              led_next   = phase + 2'd1;
            end else begin
              sub_next = sub + SUB_W'(1);
              led_next = phase;
            end
          end
        end
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        sel_next   = CENT_EDGE;
        state_next = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (sel == CENT_YELLOW) begin
          state_next        = ST_IDLE;
          sel_next          = CENT_EDGE;
          result_valid_next = 1'b1;
          done_next         = 1'b1;
          led_next          = PH_AMBIENT;
        end else begin
          sel_next   = sel + 2'd1;
          state_next = ST_SQUARE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      phase        <= PH_AMBIENT;
      sub          <= '0;
      sel          <= CENT_EDGE;
      result_valid <= 1'b0;
      led_select   <= PH_AMBIENT;
      done_res     <= 1'b0;
    end else begin
      state        <= state_next;
      phase        <= phase_next;
      sub          <= sub_next;
      sel          <= sel_next;
      result_valid <= result_valid_next;
      led_select   <= led_next;
      done_res     <= done_next;
    end
  end

`ifndef SYNTHESIS
  // completion flag only rides on a strobed word
  a_done_strobed: assert property (@(posedge clk) disable iff (rst)
    done_res |-> result_valid)
    else $error("done_res without result strobe");

  // an accepted sample gives a word next cycle or starts the distance work
  a_accept_follow: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (result_valid || busy))
    else $error("accepted sample left no trace");

  // a finished measurement asks for the ambient phase
  a_done_led: assert property (@(posedge clk) disable iff (rst)
    (result_valid && done_res) |-> (led_select == PH_AMBIENT))
    else $error("led not ambient after measurement");

  // every word appears with the controller free again
  a_valid_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while busy");
`endif

endmodule

FILE: rtl/rccs_datapath.sv
// ----------------------------------------------------------------------------
// rccs_datapath
// Datapath of the colour scorer: phase sums, centroid registers, ambient
// subtraction, three squarers shared over the centroids and the saturating
// distance adder with its result registers.
// ----------------------------------------------------------------------------
module rccs_datapath #(
  parameter int SAMPLES_PER_PHASE = rccs_pkg::SPP_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rccs_pkg::dp_cmd_t              cmd,
  input  logic [rccs_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           cfg_write,
  input  logic [rccs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rccs_pkg::CENT_W-1:0]    cfg_data,
  output logic [rccs_pkg::DIST_W-1:0]    dist_edge,
  output logic [rccs_pkg::DIST_W-1:0]    dist_metal,
  output logic [rccs_pkg::DIST_W-1:0]    dist_yellow
);
  import rccs_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(SAMPLES_PER_PHASE);
  localparam int D_W   = (((SUM_W + 3) > COMP_W) ? (SUM_W + 3) : COMP_W) + 1;
  localparam int SQ_W  = 2 * D_W - 1;
  localparam int TOT_W = SQ_W + 2;

  logic [SUM_W-1:0]        amb_sum, red_sum, grn_sum, blu_sum;
  logic signed [SUM_W:0]   red_diff, grn_diff, blu_diff;
  logic [CENT_W-1:0]       edge_cent, metal_cent, yellow_cent;
  logic [CENT_W-1:0]       cent;
  logic [SQ_W-1:0]         sq_red, sq_grn, sq_blu;
  logic [TOT_W-1:0]        total;
  logic [DIST_W-1:0]       dist_sat;

  function automatic logic [SQ_W-1:0] square_diff(input logic signed [SUM_W:0] v,
                                                  input logic [COMP_W-1:0] c);
    logic signed [D_W-1:0]   v4;
    logic signed [D_W-1:0]   ce;
    logic signed [D_W-1:0]   d;
    logic signed [2*D_W-1:0] p;
    v4 = {{(D_W-SUM_W-3){v[SUM_W]}}, v, 2'b00};
    ce = {{(D_W-COMP_W){c[COMP_W-1]}}, c};
    d  = v4 - ce;
    p  = d * d;
    return p[SQ_W-1:0];
  endfunction

  // phase sums, cleared once the differences are taken
  always_ff @(posedge clk) begin
    if (rst || cmd.diff) begin
      amb_sum <= '0;
      red_sum <= '0;
      grn_sum <= '0;
      blu_sum <= '0;
    end else if (cmd.accum) begin
      unique case (cmd.phase)
        PH_AMBIENT: amb_sum <= amb_sum + SUM_W'(sample);
        PH_RED:     red_sum <= red_sum + SUM_W'(sample);
        PH_GREEN:   grn_sum <= grn_sum + SUM_W'(sample);
        PH_BLUE:    blu_sum <= blu_sum + SUM_W'(sample);
        default:    amb_sum <= amb_sum;
      endcase
    end
  end

  // colour minus ambient
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      red_diff <= $signed({1'b0, red_sum}) - $signed({1'b0, amb_sum});
      grn_diff <= $signed({1'b0, grn_sum}) - $signed({1'b0, amb_sum});
      blu_diff <= $signed({1'b0, blu_sum}) - $signed({1'b0, amb_sum});
    end
  end

  // centroid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_cent   <= EDGE_RESET;
      metal_cent  <= METAL_RESET;
      yellow_cent <= YELLOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CENT_EDGE:   edge_cent   <= cfg_data;
        CENT_METAL:  metal_cent  <= cfg_data;
        CENT_YELLOW: yellow_cent <= cfg_data;
        default:     ;
      endcase
    end
  end

  // centroid for the current step
  always_comb begin
    unique case (cmd.sel)
      CENT_EDGE:   cent = edge_cent;
      CENT_METAL:  cent = metal_cent;
      CENT_YELLOW: cent = yellow_cent;
      default:     cent = edge_cent;
    endcase
  end

  // one square per colour, registered
  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sq_red <= square_diff(red_diff, cent[3*COMP_W-1:2*COMP_W]);
      sq_grn <= square_diff(grn_diff, cent[2*COMP_W-1:COMP_W]);
      sq_blu <= square_diff(blu_diff, cent[COMP_W-1:0]);
    end
  end

  // sum of squares with saturation
  assign total    = TOT_W'(sq_red) + TOT_W'(sq_grn) + TOT_W'(sq_blu);
  assign dist_sat = (|total[TOT_W-1:DIST_W]) ? '1 : total[DIST_W-1:0];

  // distance registers, zero on every sample so partial words read zero
  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      dist_edge   <= '0;
      dist_metal  <= '0;
      dist_yellow <= '0;
    end else if (cmd.add) begin
      case (cmd.sel)
        CENT_EDGE:   dist_edge   <= dist_sat;
        CENT_METAL:  dist_metal  <= dist_sat;
        CENT_YELLOW: dist_yellow <= dist_sat;
        default:     ;
      endcase
    end
  end

endmodule
